// ===== sv/vtd_pkg.sv =====
// shared constants, types and functions of the two digit voltmeter display
package vtd_pkg;

   localparam int ADC_W   = 10;
   localparam int DIGIT_W = 4;
   localparam int SEG_W   = 8;
   localparam int READ_W  = 7;
   localparam int X120_W  = 17;
   localparam int X12_W   = 14;

   localparam logic CMD_SAMPLE = 1'b0;
   localparam logic CMD_TICK   = 1'b1;

   localparam logic SEL_UNITS = 1'b0;
   localparam logic SEL_TENS  = 1'b1;

   localparam logic [SEG_W-1:0] SEG_DARK = 8'hFF;
   localparam int               DP_BIT   = 7;

   localparam logic [DIGIT_W-1:0] DIGIT_MAX = 4'd9;

   localparam logic [X120_W-1:0] SCALE_TENTHS = 17'd120;
   localparam logic [X12_W-1:0]  SCALE_VOLTS  = 14'd12;
   localparam logic [X12_W-1:0]  TEN_VOLTS    = 14'd10230;
   localparam logic [10:0]       FULL_SCALE   = 11'd1023;
   localparam logic [7:0]        RECIP_TEN    = 8'd205;

   typedef struct packed {
      logic [DIGIT_W-1:0] tens;
      logic [DIGIT_W-1:0] units;
      logic               whole_volts;
   } digits_type;

   // active-low anode pattern, dark above nine
   function automatic logic [SEG_W-1:0] anode_pattern(input logic [DIGIT_W-1:0] digit);
      logic [SEG_W-1:0] pat;
      case (digit)
         4'd0:    pat = 8'd192;
         4'd1:    pat = 8'd249;
         4'd2:    pat = 8'd164;
         4'd3:    pat = 8'd176;
         4'd4:    pat = 8'd153;
         4'd5:    pat = 8'd146;
         4'd6:    pat = 8'd130;
         4'd7:    pat = 8'd248;
         4'd8:    pat = 8'd128;
         4'd9:    pat = 8'd144;
         default: pat = SEG_DARK;
      endcase
      return pat;
   endfunction

   // floor(x / 1023): x = 1024*q0 + lo, so remainder is lo + q0 and stays below 2*1023
   function automatic logic [READ_W-1:0] div_by_1023(input logic [X120_W-1:0] x);
      logic [READ_W-1:0] q0;
      logic [10:0]       rem;
      q0  = x[X120_W-1:10];
      rem = {1'b0, x[9:0]} + {4'b0, q0};
      if (rem >= FULL_SCALE) begin
         return q0 + 7'd1;
      end
      return q0;
   endfunction

endpackage

// ===== sv/vtd_ifs.sv =====
// request, response and csr channel interfaces of the voltmeter display
interface vtd_req_if import vtd_pkg::*; ();
   logic             valid;
   logic             ready;
   logic             command;
   logic [ADC_W-1:0] adc_code;

   modport source (output valid, output command, output adc_code, input ready);
   modport sink   (input valid, input command, input adc_code, output ready);
endinterface

interface vtd_rsp_if import vtd_pkg::*; ();
   logic             valid;
   logic             ready;
   logic [SEG_W-1:0] segments;
   logic             digit_select;

   modport source (output valid, output segments, output digit_select, input ready);
   modport sink   (input valid, input segments, input digit_select, output ready);
endinterface

interface vtd_csr_if ();
   logic valid;
   logic ready;
   logic common_cathode;

   modport source (output valid, output common_cathode, input ready);
   modport sink   (input valid, input common_cathode, output ready);
endinterface

// ===== sv/vtd_scale.sv =====
// scales a converter code to a two digit reading in tenths or whole volts
module vtd_scale import vtd_pkg::*; (
   input  logic [ADC_W-1:0] adc_code,
   output digits_type       digits
);

   logic [X120_W-1:0] x120;
   logic [X12_W-1:0]  x12;
   logic              whole;
   logic [READ_W-1:0] reading;
   logic [14:0]       tens_prod;
   logic [READ_W-1:0] tens_times_ten;
   logic [READ_W-1:0] units_wide;

   assign x120  = {{(X120_W-ADC_W){1'b0}}, adc_code} * SCALE_TENTHS;
   assign x12   = {{(X12_W-ADC_W){1'b0}}, adc_code} * SCALE_VOLTS;
   assign whole = (x12 >= TEN_VOLTS);

   assign reading = div_by_1023(whole ? {{(X120_W-X12_W){1'b0}}, x12} : x120);

   // divide by ten via reciprocal, exact below 1029
   assign tens_prod      = {8'b0, reading} * {7'b0, RECIP_TEN};
   assign tens_times_ten = {3'b0, tens_prod[14:11]} * 7'd10;
   assign units_wide     = reading - tens_times_ten;

   assign digits.tens        = tens_prod[14:11];
   assign digits.units       = units_wide[DIGIT_W-1:0];
   assign digits.whole_volts = whole;

endmodule

// ===== sv/voltmeter_two_digit_display.sv =====
// top level: sample scaling, digit multiplexing and registered response
// latency: a tick request gives its response in the cycle after acceptance
// throughput: one request per cycle unless a held response stalls; a sample updates the digits at its accept edge
// samples produce no response; ready stays high while the response register can drain
// reset (synchronous, active high): reading 0.0 V, units digit first, common anode
module voltmeter_two_digit_display import vtd_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   vtd_req_if.sink    req_ch,
   vtd_rsp_if.source  rsp_ch,
   vtd_csr_if.sink    csr_ch
);

   logic               common_cathode_ff, common_cathode_in;
   logic [DIGIT_W-1:0] tens_digit_ff, tens_digit_in;
   logic [DIGIT_W-1:0] units_digit_ff, units_digit_in;
   logic               whole_volts_ff, whole_volts_in;
   logic               next_is_tens_ff, next_is_tens_in;
   logic               rsp_valid_ff, rsp_valid_in;
   logic [SEG_W-1:0]   segments_ff, segments_in;
   logic               digit_select_ff, digit_select_in;

   logic               req_fire;
   logic               is_tick;
   digits_type         scaled;
   logic [SEG_W-1:0]   pattern;

   vtd_scale u_scale (
      .adc_code (req_ch.adc_code),
      .digits   (scaled)
   );

   assign csr_ch.ready  = 1'b1;
   assign req_ch.ready  = !rsp_valid_ff || rsp_ch.ready;
   assign req_fire      = req_ch.valid && req_ch.ready;
   assign is_tick       = (req_ch.command == CMD_TICK);

   assign rsp_ch.valid        = rsp_valid_ff;
   assign rsp_ch.segments     = segments_ff;
   assign rsp_ch.digit_select = digit_select_ff;

   always_comb begin
      common_cathode_in = common_cathode_ff;
      tens_digit_in     = tens_digit_ff;
      units_digit_in    = units_digit_ff;
      whole_volts_in    = whole_volts_ff;
      next_is_tens_in   = next_is_tens_ff;
      rsp_valid_in      = rsp_valid_ff && !rsp_ch.ready;
      segments_in       = segments_ff;
      digit_select_in   = digit_select_ff;
      pattern           = SEG_DARK;

      if (csr_ch.valid) begin
         common_cathode_in = csr_ch.common_cathode;
      end

      if (next_is_tens_ff == SEL_TENS) begin
         pattern = anode_pattern(tens_digit_ff);
         pattern[DP_BIT] = whole_volts_ff || (tens_digit_ff > DIGIT_MAX);
      end else begin
         pattern = anode_pattern(units_digit_ff);
      end

      if (req_fire) begin
         if (is_tick) begin
            rsp_valid_in    = 1'b1;
            segments_in     = common_cathode_ff ? ~pattern : pattern;
            digit_select_in = next_is_tens_ff;
            next_is_tens_in = !next_is_tens_ff;
         end else begin
            tens_digit_in  = scaled.tens;
            units_digit_in = scaled.units;
            whole_volts_in = scaled.whole_volts;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         common_cathode_ff <= 1'b0;
         tens_digit_ff     <= '0;
         units_digit_ff    <= '0;
         whole_volts_ff    <= 1'b0;
         next_is_tens_ff   <= SEL_UNITS;
         rsp_valid_ff      <= 1'b0;
      end else begin
         common_cathode_ff <= common_cathode_in;
         tens_digit_ff     <= tens_digit_in;
         units_digit_ff    <= units_digit_in;
         whole_volts_ff    <= whole_volts_in;
         next_is_tens_ff   <= next_is_tens_in;
         rsp_valid_ff      <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      segments_ff     <= segments_in;
      digit_select_ff <= digit_select_in;
   end

   a_tick_gives_rsp: assert property (@(posedge clock) disable iff (reset)
      (req_fire && is_tick) |=> rsp_valid_ff)
      else $error("tick request lost its response");

   a_sample_no_rsp: assert property (@(posedge clock) disable iff (reset)
      (req_fire && !is_tick) |=> (rsp_valid_ff == $past(rsp_valid_ff && !rsp_ch.ready)))
      else $error("sample request produced a response");

   a_tick_alternates: assert property (@(posedge clock) disable iff (reset)
      (req_fire && is_tick) |=> (next_is_tens_ff != $past(next_is_tens_ff)))
      else $error("digit multiplexing did not alternate");

   a_digits_decimal: assert property (@(posedge clock) disable iff (reset)
      (tens_digit_ff <= DIGIT_MAX) && (units_digit_ff <= DIGIT_MAX))
      else $error("stored digit above nine");

   a_whole_volts_range: assert property (@(posedge clock) disable iff (reset)
      whole_volts_ff |-> (tens_digit_ff == 4'd1))
      else $error("whole volt reading outside ten to twelve");

endmodule
